// File: src/sorted_linked_list_table_core_assert.svh
// Assertion macros for the sorted linked list table
`ifndef SORTED_LINKED_LIST_TABLE_CORE_ASSERT_SVH
`define SORTED_LINKED_LIST_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SLLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sllt assertion failed");
`define SLLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sllt assertion failed");
`else
`define SLLT_ASSERT(lbl, prop)
`define SLLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/sllt_pkg.sv
// Package: constants, codes and state type of the sorted linked list table
`timescale 1ns / 1ps
package sllt_pkg;
    localparam int SLLT_CAPACITY    = 128;
    localparam int SLLT_VALUE_BITS  = 32;
    localparam int SLLT_KIND_BITS   = 3;
    localparam int SLLT_STATUS_BITS = 3;

    typedef enum logic [SLLT_KIND_BITS-1:0] {
        K_INSERT         = 3'd0,
        K_SEARCH         = 3'd1,
        K_REMOVE_AT      = 3'd2,
        K_REMOVE_EVERY_K = 3'd3,
        K_CLEAR          = 3'd4,
        K_READ_FIRST     = 3'd5,
        K_READ_AT        = 3'd6
    } t_kind;

    typedef enum logic [SLLT_STATUS_BITS-1:0] {
        S_OK          = 3'd0,
        S_NOT_FOUND   = 3'd1,
        S_FULL        = 3'd2,
        S_INVALID_POS = 3'd3,
        S_INVALID_K   = 3'd4,
        S_LIST_EMPTY  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_LINK,
        ST_LOCATE,
        ST_UNLINK,
        ST_KWALK,
        ST_KUNL,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } t_state;
endpackage

// File: src/sllt_if.sv
// Channel interfaces: request, response and configuration write
`timescale 1ns / 1ps
interface sllt_req_if import sllt_pkg::*; #(
    parameter int VALUE_BITS = SLLT_VALUE_BITS,
    parameter int CAPACITY   = SLLT_CAPACITY
);
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int LINK_BITS = $clog2(CAPACITY + 1);
    logic                         valid;
    logic                         ready;
    logic [SLLT_KIND_BITS-1:0]    kind;
    logic signed [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0]         position;
    logic [LINK_BITS-1:0]         every_k;
    modport source (output valid, kind, value, position, every_k, input ready);
    modport sink   (input valid, kind, value, position, every_k, output ready);
endinterface

interface sllt_rsp_if import sllt_pkg::*; #(
    parameter int VALUE_BITS = SLLT_VALUE_BITS,
    parameter int CAPACITY   = SLLT_CAPACITY
);
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int LINK_BITS = $clog2(CAPACITY + 1);
    logic                         valid;
    logic                         ready;
    logic [SLLT_STATUS_BITS-1:0]  status;
    logic signed [VALUE_BITS-1:0] result_value;
    logic [SLOT_BITS-1:0]         slot;
    logic [LINK_BITS-1:0]         next_slot;
    logic [LINK_BITS-1:0]         removed_count;
    logic [LINK_BITS-1:0]         size_now;
    modport source (output valid, status, result_value, slot, next_slot, removed_count,
                    size_now, input ready);
    modport sink   (input valid, status, result_value, slot, next_slot, removed_count,
                    size_now, output ready);
endinterface

interface sllt_cfg_if;
    logic valid;
    logic ready;
    logic descending_order;
    modport source (output valid, descending_order, input ready);
    modport sink   (input valid, descending_order, output ready);
endinterface

// File: src/sllt_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module sllt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// File: src/sorted_linked_list_table_core.sv
// Sorted linked list table: list control around value and link memories
// Flow: an accepted request walks the list node by node where needed, then ST_DONE loads the response;
// insert adds ST_INS_RD and ST_INS_WR (and ST_INS_LINK behind a node), remove_at behind a node adds
// ST_UNLINK, and each every-k unlink behind a node adds ST_KUNL.
// One item in work at a time; the next request is taken once the result is handed to the output register.
// Reset: sync, active low; a pass over every slot then chains the free slots, no request taken.
`timescale 1ns / 1ps
`include "sorted_linked_list_table_core_assert.svh"
module sorted_linked_list_table_core import sllt_pkg::*; #(
    parameter int CAPACITY   = SLLT_CAPACITY,
    parameter int VALUE_BITS = SLLT_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sllt_cfg_if.sink   i_cfg,
    sllt_req_if.sink   i_req,
    sllt_rsp_if.source o_rsp
);
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int LINK_BITS = $clog2(CAPACITY + 1);
    localparam logic [LINK_BITS-1:0] NONE    = LINK_BITS'(CAPACITY);
    localparam logic [SLOT_BITS-1:0] LAST    = SLOT_BITS'(CAPACITY - 1);
    localparam logic [LINK_BITS-1:0] ONE_L   = LINK_BITS'(1);

    // control state
    t_state               r_state, n_state;
    logic [SLOT_BITS-1:0] r_init, n_init;
    logic [LINK_BITS-1:0] r_first, n_first;
    logic [LINK_BITS-1:0] r_free, n_free;
    logic [LINK_BITS-1:0] r_count, n_count;
    logic                 r_desc;
    logic                 r_ov, n_ov;

    // operation and walk registers
    t_kind                        r_kind, n_kind;
    logic signed [VALUE_BITS-1:0] r_value, n_value;
    logic [SLOT_BITS-1:0]         r_pos, n_pos;
    logic [LINK_BITS-1:0]         r_k, n_k;
    logic [LINK_BITS-1:0]         r_cur, n_cur;
    logic [LINK_BITS-1:0]         r_prev, n_prev;
    logic [LINK_BITS-1:0]         r_kc, n_kc;

    // pending result
    t_status                      r_st, n_st;
    logic signed [VALUE_BITS-1:0] r_rv, n_rv;
    logic [SLOT_BITS-1:0]         r_sl, n_sl;
    logic [LINK_BITS-1:0]         r_nx, n_nx;
    logic [LINK_BITS-1:0]         r_rc, n_rc;

    // output register
    t_status                      r_o_st, n_o_st;
    logic signed [VALUE_BITS-1:0] r_o_rv, n_o_rv;
    logic [SLOT_BITS-1:0]         r_o_sl, n_o_sl;
    logic [LINK_BITS-1:0]         r_o_nx, n_o_nx;
    logic [LINK_BITS-1:0]         r_o_rc, n_o_rc;
    logic [LINK_BITS-1:0]         r_o_sz, n_o_sz;

    // memory ports
    logic                         rd_en;
    logic [SLOT_BITS-1:0]         rd_addr;
    logic                         lw_en;
    logic [SLOT_BITS-1:0]         lw_addr;
    logic [LINK_BITS-1:0]         lw_data;
    logic                         vw_en;
    logic signed [VALUE_BITS-1:0] vdat;
    logic [LINK_BITS-1:0]         ldat;

    logic req_xfer;
    logic rel;

    sllt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_values (
        .i_clk   (i_clk),
        .i_we    (vw_en),
        .i_waddr (r_free[SLOT_BITS-1:0]),
        .i_wdata (r_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (vdat)
    );

    sllt_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_links (
        .i_clk   (i_clk),
        .i_we    (lw_en),
        .i_waddr (lw_addr),
        .i_wdata (lw_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ldat)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_xfer    = i_req.valid && (r_state == ST_IDLE);

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_st;
    assign o_rsp.result_value  = r_o_rv;
    assign o_rsp.slot          = r_o_sl;
    assign o_rsp.next_slot     = r_o_nx;
    assign o_rsp.removed_count = r_o_rc;
    assign o_rsp.size_now      = r_o_sz;

    // ordering relation of the stored node against the operand
    assign rel = r_desc ? (vdat >= r_value) : (vdat <= r_value);

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_first = r_first;
        n_free  = r_free;
        n_count = r_count;
        n_ov    = r_ov && !o_rsp.ready;
        n_kind  = r_kind;
        n_value = r_value;
        n_pos   = r_pos;
        n_k     = r_k;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_kc    = r_kc;
        n_st    = r_st;
        n_rv    = r_rv;
        n_sl    = r_sl;
        n_nx    = r_nx;
        n_rc    = r_rc;
        n_o_st  = r_o_st;
        n_o_rv  = r_o_rv;
        n_o_sl  = r_o_sl;
        n_o_nx  = r_o_nx;
        n_o_rc  = r_o_rc;
        n_o_sz  = r_o_sz;
        rd_en   = 1'b0;
        rd_addr = r_cur[SLOT_BITS-1:0];
        lw_en   = 1'b0;
        lw_addr = r_cur[SLOT_BITS-1:0];
        lw_data = r_free;
        vw_en   = 1'b0;

        case (r_state)
            ST_INIT: begin
                // free chain: slot i links to i+1, last to none
                lw_en   = 1'b1;
                lw_addr = r_init;
                lw_data = LINK_BITS'(r_init) + ONE_L;
                n_init  = r_init + SLOT_BITS'(1);
                if (r_init == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_xfer) begin
                    n_kind  = t_kind'(i_req.kind);
                    n_value = i_req.value;
                    n_pos   = i_req.position;
                    n_k     = i_req.every_k;
                    n_st    = S_OK;
                    n_rv    = '0;
                    n_sl    = '0;
                    n_nx    = NONE;
                    n_rc    = '0;
                    n_prev  = NONE;
                    n_cur   = r_first;
                    n_kc    = ONE_L;
                    rd_addr = r_first[SLOT_BITS-1:0];
                    n_state = ST_DONE;
                    case (t_kind'(i_req.kind))
                        K_INSERT: begin
                            if (r_count >= NONE || r_free == NONE) begin
                                n_st = S_FULL;
                            end else if (r_first == NONE) begin
                                n_state = ST_INS_RD;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = ST_WALK;
                            end
                        end
                        K_SEARCH: begin
                            if (r_first == NONE) begin
                                n_st = S_NOT_FOUND;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = ST_WALK;
                            end
                        end
                        K_REMOVE_AT, K_READ_AT: begin
                            if (r_first == NONE) begin
                                n_st = S_LIST_EMPTY;
                            end else if (LINK_BITS'(i_req.position) >= NONE) begin
                                n_st = S_INVALID_POS;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = ST_LOCATE;
                            end
                        end
                        K_REMOVE_EVERY_K: begin
                            if (i_req.every_k == '0) begin
                                n_st = S_INVALID_K;
                            end else if (r_first != NONE) begin
                                rd_en   = 1'b1;
                                n_state = ST_KWALK;
                            end
                        end
                        K_CLEAR: begin
                            if (r_first != NONE) begin
                                rd_en   = 1'b1;
                                n_state = ST_CLEAR;
                            end
                        end
                        K_READ_FIRST: begin
                            if (r_first == NONE) begin
                                n_st = S_LIST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            n_st = S_OK;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // insert and search; r_cur ends at the stopping node, or at none past the tail
                if (rel && vdat == r_value) begin
                    if (r_kind == K_SEARCH) begin
                        n_rv    = vdat;
                        n_sl    = r_cur[SLOT_BITS-1:0];
                        n_nx    = ldat;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end else if (rel) begin
                    n_prev  = r_cur;
                    n_cur   = ldat;
                    rd_addr = ldat[SLOT_BITS-1:0];
                    if (ldat == NONE) begin
                        if (r_kind == K_SEARCH) begin
                            n_st    = S_NOT_FOUND;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_INS_RD;
                        end
                    end else begin
                        rd_en = 1'b1;
                    end
                end else begin
                    if (r_kind == K_SEARCH) begin
                        n_st    = S_NOT_FOUND;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_free[SLOT_BITS-1:0];
                n_state = ST_INS_WR;
            end
            ST_INS_WR: begin
                vw_en   = 1'b1;
                lw_en   = 1'b1;
                lw_addr = r_free[SLOT_BITS-1:0];
                lw_data = r_cur;
                n_free  = ldat;
                n_count = r_count + ONE_L;
                n_rv    = r_value;
                n_sl    = r_free[SLOT_BITS-1:0];
                n_nx    = r_cur;
                if (r_prev == NONE) begin
                    n_first = r_free;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_INS_LINK;
                end
            end
            ST_INS_LINK: begin
                lw_en   = 1'b1;
                lw_addr = r_prev[SLOT_BITS-1:0];
                lw_data = LINK_BITS'(r_sl);
                n_state = ST_DONE;
            end
            ST_LOCATE: begin
                if (r_cur == LINK_BITS'(r_pos)) begin
                    n_rv    = vdat;
                    n_sl    = r_pos;
                    n_nx    = ldat;
                    n_state = ST_DONE;
                    if (r_kind == K_REMOVE_AT) begin
                        if (r_prev == NONE) begin
                            n_first = ldat;
                            lw_en   = 1'b1;
                            lw_addr = r_pos;
                            lw_data = r_free;
                            n_free  = LINK_BITS'(r_pos);
                            n_count = r_count - ONE_L;
                        end else begin
                            lw_en   = 1'b1;
                            lw_addr = r_prev[SLOT_BITS-1:0];
                            lw_data = ldat;
                            n_state = ST_UNLINK;
                        end
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = ldat;
                    rd_addr = ldat[SLOT_BITS-1:0];
                    if (ldat == NONE) begin
                        n_st    = S_INVALID_POS;
                        n_state = ST_DONE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_UNLINK: begin
                lw_en   = 1'b1;
                lw_addr = r_pos;
                lw_data = r_free;
                n_free  = LINK_BITS'(r_pos);
                n_count = r_count - ONE_L;
                n_state = ST_DONE;
            end
            ST_KWALK: begin
                n_cur   = ldat;
                rd_addr = ldat[SLOT_BITS-1:0];
                if (r_kc == r_k) begin
                    // k-th node: push on free chain, relink predecessor (or the head)
                    lw_en   = 1'b1;
                    lw_data = r_free;
                    n_free  = r_cur;
                    n_count = r_count - ONE_L;
                    n_rc    = r_rc + ONE_L;
                    n_kc    = ONE_L;
                    if (r_prev == NONE) begin
                        n_first = ldat;
                        if (ldat == NONE) begin
                            n_state = ST_DONE;
                        end else begin
                            rd_en = 1'b1;
                        end
                    end else begin
                        n_state = ST_KUNL;
                    end
                end else begin
                    n_prev = r_cur;
                    n_kc   = r_kc + ONE_L;
                    if (ldat == NONE) begin
                        n_state = ST_DONE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_KUNL: begin
                lw_en   = 1'b1;
                lw_addr = r_prev[SLOT_BITS-1:0];
                lw_data = r_cur;
                if (r_cur == NONE) begin
                    n_state = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ST_KWALK;
                end
            end
            ST_CLEAR: begin
                lw_en   = 1'b1;
                lw_data = r_free;
                n_free  = r_cur;
                n_first = ldat;
                n_cur   = ldat;
                n_count = r_count - ONE_L;
                n_rc    = r_rc + ONE_L;
                rd_addr = ldat[SLOT_BITS-1:0];
                if (ldat == NONE) begin
                    n_state = ST_DONE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ST_READ: begin
                n_rv    = vdat;
                n_sl    = r_cur[SLOT_BITS-1:0];
                n_nx    = ldat;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_st;
                    n_o_rv  = r_rv;
                    n_o_sl  = r_sl;
                    n_o_nx  = r_nx;
                    n_o_rc  = r_rc;
                    n_o_sz  = r_count;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_init  <= '0;
            r_first <= NONE;
            r_free  <= '0;
            r_count <= '0;
            r_desc  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_first <= n_first;
            r_free  <= n_free;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg.valid) begin
                r_desc <= i_cfg.descending_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_kc    <= n_kc;
        r_st    <= n_st;
        r_rv    <= n_rv;
        r_sl    <= n_sl;
        r_nx    <= n_nx;
        r_rc    <= n_rc;
        r_o_st  <= n_o_st;
        r_o_rv  <= n_o_rv;
        r_o_sl  <= n_o_sl;
        r_o_nx  <= n_o_nx;
        r_o_rc  <= n_o_rc;
        r_o_sz  <= n_o_sz;
    end

    `SLLT_ASSERT(a_count_bound, r_count <= NONE)
    `SLLT_ASSERT(a_empty_match, (r_state == ST_IDLE) |-> ((r_first == NONE) == (r_count == '0)))
    `SLLT_ASSERT(a_full_match, (r_state == ST_IDLE) |-> ((r_free == NONE) == (r_count == NONE)))
    `SLLT_ASSERT_NEXT(a_busy_after, req_xfer, r_state != ST_IDLE)
endmodule
